@@ rtl/core/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the pwm channel controller
// Register map codes, bus event kinds and the command that passes from the
// front decoder to the back executor.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // defaults for the top level parameters
  localparam int unsigned CHANNELS_DEF     = 16;
  localparam int unsigned COUNTER_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SHADOW_IDX_W = 6;
  localparam int unsigned TIME_W       = 12;
  localparam int unsigned PWM_OUT_W    = 16;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // register map
  localparam logic [BYTE_W-1:0] ADDR_MODE_ONE  = 8'h00;
  localparam logic [BYTE_W-1:0] ADDR_MODE_TWO  = 8'h01;
  localparam logic [BYTE_W-1:0] ADDR_CHAN_BASE = 8'h06;
  localparam logic [BYTE_W-1:0] ADDR_PRESCALE  = 8'hFE;

  // bit positions in mode one and in the off high byte
  localparam int unsigned AUTO_INC_BIT  = 5;
  localparam int unsigned FORCE_OFF_BIT = 4;

  // reset values
  localparam logic [BYTE_W-1:0] PRESCALE_RESET = 8'd30;

  // bus event kinds on the input channel
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  // operations carried out by the back part
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_PRESCALE = 3'd1,
    OP_SHADOW   = 3'd2,
    OP_LATCH    = 3'd3,
    OP_TICK     = 3'd4
  } op_e;

  // decoded command
  typedef struct packed {
    op_e                     op;
    logic [SHADOW_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]       data;
  } cmd_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/pcc_front.sv @@
// ----------------------------------------------------------------------------
// pcc_front: bus event decoder
// Owns the register pointer and the auto-increment flag, resolves each data
// byte to its target and pushes one command per accepted beat.
// ----------------------------------------------------------------------------
module pcc_front #(
  parameter int unsigned CHANNELS = pcc_pkg::CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                in_func_i,
  input  logic [pcc_pkg::BYTE_W-1:0] in_byte_i,
  input  pcc_pkg::q_stat_t          q_stat_i,
  output logic                      push_o,
  output pcc_pkg::cmd_t             cmd_o
);
  import pcc_pkg::*;

  localparam int unsigned ChanEnd = ADDR_CHAN_BASE + 4 * CHANNELS;

  logic [BYTE_W-1:0] ptr_q, ptr_d;
  logic              auto_inc_q, auto_inc_d;
  logic              accept;
  logic              in_chan;
  logic              inc_en;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // pointer falls in the channel window
  assign in_chan = (ptr_q >= ADDR_CHAN_BASE) && ({1'b0, ptr_q} < 9'(ChanEnd));

  // classify the beat and update the pointer
  always_comb begin
    ptr_d      = ptr_q;
    auto_inc_d = auto_inc_q;
    inc_en     = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = SHADOW_IDX_W'(ptr_q - ADDR_CHAN_BASE);
    cmd_o.data = in_byte_i;
    case (func_e'(in_func_i))
      FUNC_START: begin
        ptr_d = in_byte_i;
      end
      FUNC_DATA: begin
        inc_en = auto_inc_q;
        if (ptr_q == ADDR_MODE_ONE) begin
          auto_inc_d = in_byte_i[AUTO_INC_BIT];
          inc_en     = in_byte_i[AUTO_INC_BIT];
        end else if (ptr_q == ADDR_MODE_TWO) begin
          cmd_o.op = OP_NONE;
        end else if (ptr_q == ADDR_PRESCALE) begin
          cmd_o.op = OP_PRESCALE;
        end else if (in_chan) begin
          cmd_o.op = OP_SHADOW;
        end
        if (inc_en) begin
          ptr_d = ptr_q + 8'd1;
        end
      end
      FUNC_STOP: begin
        cmd_o.op = OP_LATCH;
      end
      FUNC_TICK: begin
        cmd_o.op = OP_TICK;
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

  // pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      auto_inc_q <= 1'b0;
    end else if (accept) begin
      ptr_q      <= ptr_d;
      auto_inc_q <= auto_inc_d;
    end
  end

endmodule

@@ rtl/core/pcc_queue.sv @@
// ----------------------------------------------------------------------------
// pcc_queue: short command queue
// Parts the front decoder from the back executor so each side can stall.
// ----------------------------------------------------------------------------
module pcc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcc_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output pcc_pkg::cmd_t    cmd_o,
  output pcc_pkg::q_stat_t stat_o
);
  import pcc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign cmd_o        = entry_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

@@ rtl/core/pcc_back.sv @@
// ----------------------------------------------------------------------------
// pcc_back: command executor and output stage
// Holds shadow and active channel registers, the prescale divider and the
// pwm counter, and registers one result beat per executed command.
// ----------------------------------------------------------------------------
module pcc_back #(
  parameter int unsigned CHANNELS     = pcc_pkg::CHANNELS_DEF,
  parameter int unsigned COUNTER_BITS = pcc_pkg::COUNTER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcc_pkg::q_stat_t             q_stat_i,
  input  pcc_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pcc_pkg::PWM_OUT_W-1:0] out_pwm_o,
  output logic [pcc_pkg::TIME_W-1:0]    out_count_o
);
  import pcc_pkg::*;

  localparam int unsigned Entries = 4 * CHANNELS;
  localparam int unsigned IdxW    = $clog2(Entries);

  logic [BYTE_W-1:0]       shadow_q [Entries];
  logic [BYTE_W-1:0]       shadow_d [Entries];
  logic [TIME_W-1:0]       on_q  [CHANNELS];
  logic [TIME_W-1:0]       on_d  [CHANNELS];
  logic [TIME_W-1:0]       off_q [CHANNELS];
  logic [TIME_W-1:0]       off_d [CHANNELS];
  logic [CHANNELS-1:0]     force_q, force_d;
  logic [BYTE_W-1:0]       prescale_q, prescale_d;
  logic [BYTE_W-1:0]       div_q, div_d;
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
  logic [CHANNELS-1:0]     level;
  logic                    out_valid_q, out_valid_d;
  logic [PWM_OUT_W-1:0]    out_pwm_q;
  logic [TIME_W-1:0]       out_count_q;
  logic [31:0]             cnt_wide;

  // take a command whenever the output register is free or being drained
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  // state update for the command at the queue head
  always_comb begin
    shadow_d   = shadow_q;
    on_d       = on_q;
    off_d      = off_q;
    force_d    = force_q;
    prescale_d = prescale_q;
    div_d      = div_q;
    cnt_d      = cnt_q;
    if (pop_o) begin
      case (cmd_i.op)
        OP_PRESCALE: prescale_d = cmd_i.data;
        OP_SHADOW:   shadow_d[cmd_i.idx[IdxW-1:0]] = cmd_i.data;
        OP_LATCH: begin
          for (int n = 0; n < CHANNELS; n++) begin
            on_d[n]    = {shadow_q[4*n+1][3:0], shadow_q[4*n]};
            off_d[n]   = {shadow_q[4*n+3][3:0], shadow_q[4*n+2]};
            force_d[n] = shadow_q[4*n+3][FORCE_OFF_BIT];
          end
        end
        OP_TICK: begin
          if (div_q == prescale_q) begin
            div_d = '0;
            cnt_d = cnt_q + COUNTER_BITS'(1);
          end else begin
            div_d = div_q + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // channel levels from the state after the command
  always_comb begin
    logic [COUNTER_BITS-1:0] on_m;
    logic [COUNTER_BITS-1:0] off_m;
    for (int n = 0; n < CHANNELS; n++) begin
      on_m  = COUNTER_BITS'(on_d[n]);
      off_m = COUNTER_BITS'(off_d[n]);
      if (force_d[n]) begin
        level[n] = 1'b0;
      end else if (on_m < off_m) begin
        level[n] = (cnt_d >= on_m) && (cnt_d < off_m);
      end else if (on_m > off_m) begin
        level[n] = (cnt_d >= on_m) || (cnt_d < off_m);
      end else begin
        level[n] = 1'b0;
      end
    end
  end

  assign cnt_wide = 32'(cnt_d);

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        shadow_q[i] <= '0;
      end
      for (int n = 0; n < CHANNELS; n++) begin
        on_q[n]  <= '0;
        off_q[n] <= '0;
      end
      force_q     <= '1;
      prescale_q  <= PRESCALE_RESET;
      div_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      shadow_q    <= shadow_d;
      on_q        <= on_d;
      off_q       <= off_d;
      force_q     <= force_d;
      prescale_q  <= prescale_d;
      div_q       <= div_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_pwm_q   <= PWM_OUT_W'(level);
      out_count_q <= cnt_wide[TIME_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pwm_o   = out_pwm_q;
  assign out_count_o = out_count_q;

`ifndef ASSERT_OFF
  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == OP_TICK && div_q == prescale_q)
      |=> cnt_q == $past(cnt_q) + COUNTER_BITS'(1))
    else $error("pwm counter did not advance on divider wrap");
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op != OP_TICK) |=> $stable(cnt_q))
    else $error("pwm counter moved without a tick");
  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("executed command gave no result beat");
`endif

endmodule

@@ rtl/core/i2c_pwm_channel_controller.sv @@
// ----------------------------------------------------------------------------
// i2c_pwm_channel_controller: sixteen channel pwm output device
// Byte-wide register bus events and oscillator ticks in, channel levels and
// the shared pwm counter out, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage
//   slave side: s_tuser carries the event kind (start with pointer, data,
//   stop, tick), s_tdata carries the pointer or data byte.
//   master side: every input beat gives exactly one result beat holding the
//   channel levels and the counter as they stand after that beat.
//   throughput: one beat per cycle, sustained while m_tready stays high; the front
//   decoder, the two-entry command queue and the back executor each take one beat a cycle.
//   path: when unstalled, an accepted input beat is written into the queue,
//   then passes through the executor into the output register.
//   stop copies all shadow bytes to the active registers in the same cycle.
//   reset: all channels forced off, prescale 30, pointer and counter zero,
//   both queue and output register empty.
//   stall: a held result keeps the output register; the queue then fills
//   to its two entries and s_tready drops until the receiver drains.
// ----------------------------------------------------------------------------
module i2c_pwm_channel_controller #(
  parameter int unsigned CHANNELS     = pcc_pkg::CHANNELS_DEF,
  parameter int unsigned COUNTER_BITS = pcc_pkg::COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [15:0] pwm_out, [27:16] pwm_count, [31:28] zero
);
  import pcc_pkg::*;

  q_stat_t              q_stat;
  cmd_t                 push_cmd;
  cmd_t                 head_cmd;
  logic                 push;
  logic                 pop;
  logic [PWM_OUT_W-1:0] pwm_out;
  logic [TIME_W-1:0]    pwm_count;

  // front: accept and classify bus beats
  pcc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .in_func_i  (s_tuser),
    .in_byte_i  (s_tdata),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // command queue between the two halves
  pcc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  // back: execute commands and drive result beats
  pcc_back #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_pwm_o   (pwm_out),
    .out_count_o (pwm_count)
  );

  assign m_tdata = {4'b0000, pwm_count, pwm_out};

endmodule
